>>> design/xalu_pkg.sv
// Shared types, operation codes and helpers for the x86 integer ALU.
`default_nettype none
package xalu_pkg;

   localparam logic [4:0] OP_ADD  = 5'd0;
   localparam logic [4:0] OP_ADC  = 5'd1;
   localparam logic [4:0] OP_SUB  = 5'd2;
   localparam logic [4:0] OP_SBB  = 5'd3;
   localparam logic [4:0] OP_MUL  = 5'd4;
   localparam logic [4:0] OP_IMUL = 5'd5;
   localparam logic [4:0] OP_DIV  = 5'd6;
   localparam logic [4:0] OP_IDIV = 5'd7;
   localparam logic [4:0] OP_MOD  = 5'd8;
   localparam logic [4:0] OP_IMOD = 5'd9;
   localparam logic [4:0] OP_AND  = 5'd10;
   localparam logic [4:0] OP_XOR  = 5'd11;
   localparam logic [4:0] OP_OR   = 5'd12;
   localparam logic [4:0] OP_SHL  = 5'd13;
   localparam logic [4:0] OP_SHR  = 5'd14;
   localparam logic [4:0] OP_SAR  = 5'd15;
   localparam logic [4:0] OP_SAL  = 5'd16;

   localparam logic [1:0] SZ_8  = 2'd0;
   localparam logic [1:0] SZ_16 = 2'd1;

   localparam logic [5:0] DIV_LAST = 6'd63;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_cap;
      logic div_init;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_div;
      logic div_last;
   } status_type;

   function automatic logic [31:0] size_mask(input logic [1:0] sz);
      unique case (sz)
         SZ_8:    size_mask = 32'h0000_00FF;
         SZ_16:   size_mask = 32'h0000_FFFF;
         default: size_mask = 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [31:0] sext32(input logic [31:0] v, input logic [1:0] sz);
      unique case (sz)
         SZ_8:    sext32 = {{24{v[7]}}, v[7:0]};
         SZ_16:   sext32 = {{16{v[15]}}, v[15:0]};
         default: sext32 = v;
      endcase
   endfunction

   function automatic logic top_bit(input logic [31:0] v, input logic [1:0] sz);
      unique case (sz)
         SZ_8:    top_bit = v[7];
         SZ_16:   top_bit = v[15];
         default: top_bit = v[31];
      endcase
   endfunction

endpackage
`default_nettype wire

>>> design/xalu_ctrl.sv
// Controller state machine sequencing accept, execute, divide and write-back.
`default_nettype none
module xalu_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire xalu_pkg::status_type status,
   output xalu_pkg::cmd_type        cmd
);
   import xalu_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_div) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end else begin
               cmd.mul_cap = 1'b1;
               state_in    = ST_FIN;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   a_fin_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> out_free) else $error("write-back over pending result");
   a_acc_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC)) else $error("accept not followed by exec");
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && status.div_last) |=> (state_ff == ST_FIN))
      else $error("divider did not finish");
   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff) else $error("finished result not presented");

endmodule
`default_nettype wire

>>> design/xalu_dp.sv
// Datapath: operand registers, ALU, multiplier, iterative divider, flags and result register.
`default_nettype none
module xalu_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire xalu_pkg::cmd_type  cmd,
   output xalu_pkg::status_type    status,
   input  wire logic [4:0]         req_mode,
   input  wire logic [63:0]        req_operand_a,
   input  wire logic [63:0]        req_operand_b,
   input  wire logic [1:0]         req_size_code,
   output logic [63:0]             rsp_result,
   output logic                    rsp_carry_out,
   output logic                    rsp_parity_out,
   output logic                    rsp_zero_out,
   output logic                    rsp_sign_out,
   output logic                    rsp_overflow_out
);
   import xalu_pkg::*;

   logic [4:0]  mode_ff;
   logic [63:0] a_ff, b_ff;
   logic [1:0]  size_ff;
   logic [63:0] prod_ff;
   logic [63:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [32:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff;
   logic        negq_ff, negq_in, negr_ff, negr_in, dz_ff, dz_in;
   logic        cf_ff, pf_ff, zf_ff, sf_ff, of_ff;
   logic        cf_in, pf_in, zf_in, sf_in, of_in;
   logic [63:0] res_ff, res_in;
   logic        ocf_ff, opf_ff, ozf_ff, osf_ff, oof_ff;

   logic [31:0] m, aa, bb, sa, sb, r;
   logic        sgn;
   logic [32:0] ma, mb, dvs33, shifted, diff;
   logic [65:0] prod_full;
   logic [63:0] dvd, dvd_mag, qf;
   logic [31:0] remf;
   logic [32:0] sum, sub_rhs;
   logic [63:0] sh64;
   logic [4:0]  c, cm1;
   logic        set_pzs, mul_hi;

   assign m   = size_mask(size_ff);
   assign aa  = a_ff[31:0] & m;
   assign bb  = b_ff[31:0] & m;
   assign sa  = sext32(aa, size_ff);
   assign sb  = sext32(bb, size_ff);
   assign sgn = (mode_ff == OP_IMUL) || (mode_ff == OP_IDIV) || (mode_ff == OP_IMOD);

   assign ma        = sgn ? {sa[31], sa} : {1'b0, aa};
   assign mb        = sgn ? {sb[31], sb} : {1'b0, bb};
   assign prod_full = 66'($signed(ma) * $signed(mb));

   assign status.is_div   = (mode_ff == OP_DIV) || (mode_ff == OP_IDIV) ||
                            (mode_ff == OP_MOD) || (mode_ff == OP_IMOD);
   assign status.div_last = (cnt_ff == DIV_LAST);

   always_comb begin
      unique case (size_ff)
         SZ_8:    dvd = sgn ? {{48{b_ff[15]}}, b_ff[15:0]} : {48'b0, b_ff[15:0]};
         SZ_16:   dvd = sgn ? {{32{b_ff[31]}}, b_ff[31:0]} : {32'b0, b_ff[31:0]};
         default: dvd = b_ff;
      endcase
      dvs33   = ma;
      dvd_mag = dvd[63] && sgn ? 64'(-dvd) : dvd;
      dvs_in  = dvs33[32] ? 33'(-dvs33) : dvs33;
      negr_in = sgn && dvd[63];
      negq_in = sgn && (dvd[63] != dvs33[32]);
      dz_in   = (aa == 32'b0);
      shifted = {rem_ff, quot_ff[63]};
      diff    = shifted - dvs_ff;
      if (cmd.div_init) begin
         quot_in = dvd_mag;
         rem_in  = 32'b0;
      end else if (shifted >= dvs_ff) begin
         quot_in = {quot_ff[62:0], 1'b1};
         rem_in  = diff[31:0];
      end else begin
         quot_in = {quot_ff[62:0], 1'b0};
         rem_in  = shifted[31:0];
      end
      qf   = negq_ff ? 64'(-quot_ff) : quot_ff;
      remf = negr_ff ? 32'(-rem_ff) : rem_ff;
   end

   always_comb begin
      cf_in   = cf_ff;
      pf_in   = pf_ff;
      zf_in   = zf_ff;
      sf_in   = sf_ff;
      of_in   = of_ff;
      r       = 32'b0;
      res_in  = 64'b0;
      set_pzs = 1'b0;
      c       = a_ff[4:0];
      cm1     = c - 5'd1;
      sum     = {1'b0, aa} + {1'b0, bb} + {32'b0, (mode_ff == OP_ADC) & cf_ff};
      sub_rhs = {1'b0, aa} + {32'b0, (mode_ff == OP_SBB) & cf_ff};
      sh64    = {32'b0, bb} << c;
      unique case (size_ff)
         SZ_8:    mul_hi = (prod_ff[63:8] != 56'b0);
         SZ_16:   mul_hi = (prod_ff[63:16] != 48'b0);
         default: mul_hi = (prod_ff[63:32] != 32'b0);
      endcase
      unique case (mode_ff)
         OP_ADD, OP_ADC: begin
            r = sum[31:0] & m;
            unique case (size_ff)
               SZ_8:    cf_in = sum[8];
               SZ_16:   cf_in = sum[16];
               default: cf_in = sum[32];
            endcase
            of_in   = top_bit(~(aa ^ bb) & (aa ^ r), size_ff);
            set_pzs = 1'b1;
         end
         OP_SUB, OP_SBB: begin
            r       = (bb - sub_rhs[31:0]) & m;
            cf_in   = ({1'b0, bb} < sub_rhs);
            of_in   = top_bit((aa ^ bb) & (bb ^ r), size_ff);
            set_pzs = 1'b1;
         end
         OP_MUL: begin
            res_in = prod_ff;
            cf_in  = mul_hi;
            of_in  = mul_hi;
         end
         OP_IMUL: res_in = prod_ff;
         OP_DIV, OP_IDIV: res_in = dz_ff ? 64'b0 : {32'b0, qf[31:0] & m};
         OP_MOD, OP_IMOD: res_in = dz_ff ? 64'b0 : {32'b0, remf};
         OP_AND, OP_XOR, OP_OR: begin
            r = (mode_ff == OP_AND) ? (aa & bb) :
                (mode_ff == OP_XOR) ? (aa ^ bb) : (aa | bb);
            cf_in   = 1'b0;
            of_in   = 1'b0;
            set_pzs = 1'b1;
         end
         OP_SHL, OP_SHR, OP_SAR, OP_SAL: begin
            if (c == 5'd0) begin
               r = bb;
            end else begin
               set_pzs = 1'b1;
               if (mode_ff == OP_SHR) begin
                  cf_in = bb[cm1];
                  r     = (bb >> c) & m;
               end else if (mode_ff == OP_SAR) begin
                  cf_in = sb[cm1];
                  r     = 32'($signed(sb) >>> c) & m;
                  of_in = 1'b0;
               end else begin
                  unique case (size_ff)
                     SZ_8:    cf_in = sh64[8];
                     SZ_16:   cf_in = sh64[16];
                     default: cf_in = sh64[32];
                  endcase
                  r = sh64[31:0] & m;
               end
            end
         end
         default: r = 32'b0;
      endcase
      if (!(status.is_div || mode_ff == OP_MUL || mode_ff == OP_IMUL)) res_in = {32'b0, r};
      if (set_pzs) begin
         pf_in = ~^r[7:0];
         zf_in = (r == 32'b0);
         sf_in = top_bit(r, size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cf_ff <= 1'b0;
         pf_ff <= 1'b0;
         zf_ff <= 1'b0;
         sf_ff <= 1'b0;
         of_ff <= 1'b0;
      end else if (cmd.finish) begin
         cf_ff <= cf_in;
         pf_ff <= pf_in;
         zf_ff <= zf_in;
         sf_ff <= sf_in;
         of_ff <= of_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         a_ff    <= req_operand_a;
         b_ff    <= req_operand_b;
         size_ff <= req_size_code;
      end
      if (cmd.mul_cap) prod_ff <= prod_full[63:0];
      if (cmd.div_init) begin
         dvs_ff  <= dvs_in;
         negq_ff <= negq_in;
         negr_ff <= negr_in;
         dz_ff   <= dz_in;
         cnt_ff  <= 6'd0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 6'd1;
      end
      if (cmd.div_init || cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
      if (cmd.finish) begin
         res_ff <= res_in;
         ocf_ff <= cf_in;
         opf_ff <= pf_in;
         ozf_ff <= zf_in;
         osf_ff <= sf_in;
         oof_ff <= of_in;
      end
   end

   assign rsp_result       = res_ff;
   assign rsp_carry_out    = ocf_ff;
   assign rsp_parity_out   = opf_ff;
   assign rsp_zero_out     = ozf_ff;
   assign rsp_sign_out     = osf_ff;
   assign rsp_overflow_out = oof_ff;

endmodule
`default_nettype wire

>>> design/x86_integer_alu_with_flags_unit.sv
// Top level of the x86 integer ALU with CF/PF/ZF/SF/OF flags.
//  channel | handshake            | payload
//  req     | req_valid/req_ready  | mode, operand_a, operand_b, size_code
//  rsp     | rsp_valid/rsp_ready  | result, carry/parity/zero/sign/overflow
// One transaction at a time: accept, execute, write-back for most ops;
// divide and modulo add the steps of the one-bit-per-cycle restoring
// divider between execute and write-back.
// Result register decouples rsp: a new transaction is taken while a result waits.
// Synchronous reset clears flags, state and rsp_valid.
`default_nettype none
module x86_integer_alu_with_flags_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [4:0]  req_mode,
   input  wire logic [63:0] req_operand_a,
   input  wire logic [63:0] req_operand_b,
   input  wire logic [1:0]  req_size_code,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_result,
   output logic             rsp_carry_out,
   output logic             rsp_parity_out,
   output logic             rsp_zero_out,
   output logic             rsp_sign_out,
   output logic             rsp_overflow_out
);
   import xalu_pkg::*;

   cmd_type    cmd;
   status_type status;

   xalu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   xalu_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .req_size_code    (req_size_code),
      .rsp_result       (rsp_result),
      .rsp_carry_out    (rsp_carry_out),
      .rsp_parity_out   (rsp_parity_out),
      .rsp_zero_out     (rsp_zero_out),
      .rsp_sign_out     (rsp_sign_out),
      .rsp_overflow_out (rsp_overflow_out)
   );

endmodule
`default_nettype wire
